// File: src/md5_pkg.sv
// Package with MD5 constants, types and round helper functions.
package md5_pkg;

  localparam int BlockBytes = 64;
  localparam int IdxW = 6;
  localparam int WordW = 32;
  localparam int PadStart = 56;

  localparam logic [WordW-1:0] InitA = 32'h67452301;
  localparam logic [WordW-1:0] InitB = 32'hefcdab89;
  localparam logic [WordW-1:0] InitC = 32'h98badcfe;
  localparam logic [WordW-1:0] InitD = 32'h10325476;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [WordW-1:0] word_t;

  // Round control handed from the sequencer to the round unit.
  typedef struct packed {
    logic       start;
    logic       step;
    logic [5:0] round;
  } rnd_ctl_t;

  function automatic word_t step_const(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
      4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
      4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
      4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // Message word index used by a round.
  function automatic logic [3:0] word_index(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

// File: src/md5_buf.sv
// Block buffer: 16 x 32-bit word memory with byte writes and a registered read.
module md5_buf (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [5:0]        wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [3:0]        rd_addr,
  output md5_pkg::word_t    rd_data
);
  import md5_pkg::*;

  logic [3:0][7:0] mem [16];

  // Byte lane write and registered word read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][wr_addr[1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: src/md5_round.sv
// Round unit: chaining words and the working registers, one round per cycle.
module md5_round (
  input  logic             clk,
  input  logic             rst,
  input  md5_pkg::rnd_ctl_t ctl,
  input  md5_pkg::word_t   w,
  input  logic             fold,
  input  logic             reinit,
  output logic [127:0]     chain
);
  import md5_pkg::*;

  word_t ha, hb, hc, hd, a, b, c, d;
  word_t f, t, s;

  // Round function for the current round.
  always_comb begin
    case (ctl.round[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    t = a + f + w + step_const(ctl.round);
    s = (t << rot_amount(ctl.round)) | (t >> (6'd32 - {1'b0, rot_amount(ctl.round)}));
  end

  // Chaining and working registers.
  always_ff @(posedge clk) begin
    if (rst || reinit) begin
      ha <= InitA; hb <= InitB; hc <= InitC; hd <= InitD;
    end else if (fold) begin
      ha <= ha + a; hb <= hb + b; hc <= hc + c; hd <= hd + d;
    end
    if (ctl.start) begin
      a <= ha; b <= hb; c <= hc; d <= hd;
    end else if (ctl.step) begin
      a <= d; d <= c; c <= b; b <= b + s;
    end
  end

  assign chain = {ha, hb, hc, hd};
endmodule

// File: src/md5_message_digest_unit.sv
// Top level of the byte-serial MD5 digest unit.
// Usage: one byte beat per s_tvalid/s_tready handshake on the slave side.
// s_tdata holds data_byte, s_tuser holds byte_present, s_tlast holds
// end_of_message. A plain byte is written into the buffer and the unit
// stays ready; the 64th byte of a block starts a compression (one round
// per cycle through the block buffer memory read port, plus load and
// fold). At message end the padding bytes are written one per cycle into
// the buffer, followed by one or two compressions. The digest is held in
// an output register on m_tdata until the receiver takes it; a stalled
// receiver only holds the next message at its first end, while plain
// bytes keep flowing. Reset loads the initial chaining values and clears
// the fill count and bit length; the buffer itself is not cleared, as
// every read follows a write.
module md5_message_digest_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tuser,   // [0] byte_present
  input  logic         s_tlast,   // end_of_message
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // [63:0] digest_first_half, [127:64] digest_second_half
);
  import md5_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PAD  = 5'b00010,
    S_RUN  = 5'b00100,
    S_FOLD = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  logic [5:0] fill;
  logic [63:0] bits;
  logic [6:0] rcnt;
  logic fin, last_blk, out_pend;
  logic wr_en;
  logic [5:0] wr_addr;
  logic [7:0] wr_data;
  logic [5:0] rd_round;
  word_t w;
  rnd_ctl_t ctl;
  logic [127:0] chain;
  logic acc;

  assign s_tready = (state == S_IDLE) && !(s_tlast && m_tvalid);
  assign acc = s_tvalid && s_tready;
  assign rd_round = (state == S_RUN) ? 6'(rcnt + 7'd1) : 6'd0;

  // Buffer write port: message bytes, pad byte, zeros and length.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = fill;
    wr_data = s_tdata;
    if (acc && s_tuser) begin
      wr_en = 1'b1;
    end else if (state == S_PAD) begin
      wr_en = 1'b1;
      if (fill >= 6'(PadStart) && last_blk) begin
        wr_data = bits[{fill[2:0], 3'b000} +: 8];
      end else if (!out_pend) begin
        wr_data = PadByte;
      end else begin
        wr_data = 8'h00;
      end
    end
  end

  md5_buf u_buf (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(word_index(rd_round)), .rd_data(w)
  );

  assign ctl.start = (state == S_RUN) && rcnt == 7'd127;
  assign ctl.step  = (state == S_RUN) && rcnt != 7'd127;
  assign ctl.round = rcnt[5:0];

  md5_round u_round (
    .clk(clk), .rst(rst), .ctl(ctl), .w(w),
    .fold(state == S_FOLD), .reinit(state == S_OUT), .chain(chain)
  );

  // Sequencer. out_pend marks that the pad byte has been written.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; fill <= '0; bits <= '0; rcnt <= '0;
      fin <= 1'b0; last_blk <= 1'b0; out_pend <= 1'b0; m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            fin <= s_tlast;
            if (s_tuser) begin
              fill <= fill + 6'd1;
              bits <= bits + 64'd8;
            end
            if (s_tuser && fill == 6'd63) begin
              state <= S_RUN; rcnt <= 7'd127;
            end else if (s_tlast) begin
              state <= S_PAD; out_pend <= 1'b0;
              last_blk <= ((s_tuser ? fill + 6'd1 : fill) < 6'd56)
                          && !(s_tuser && fill == 6'd63);
            end
          end
        end
        S_PAD: begin
          out_pend <= 1'b1;
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_RUN; rcnt <= 7'd127;
          end
        end
        S_RUN: begin
          rcnt <= rcnt + 7'd1;
          if (rcnt == 7'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          if (!fin) begin
            state <= S_IDLE;
          end else if (!out_pend) begin
            state <= S_PAD;
            last_blk <= 1'b1;
          end else if (last_blk) begin
            state <= S_OUT;
          end else begin
            state <= S_PAD; last_blk <= 1'b1;
          end
        end
        S_OUT: begin
          state <= S_IDLE; m_tvalid <= 1'b1;
          fill <= '0; bits <= '0; fin <= 1'b0; out_pend <= 1'b0; last_blk <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Digest register, byte 0 of each half in the top bits.
  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      m_tdata[63:0]   <= {chain[103:96], chain[111:104], chain[119:112], chain[127:120],
                          chain[71:64], chain[79:72], chain[87:80], chain[95:88]};
      m_tdata[127:64] <= {chain[39:32], chain[47:40], chain[55:48], chain[63:56],
                          chain[7:0], chain[15:8], chain[23:16], chain[31:24]};
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE) else $error("ready outside idle");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> m_tvalid) else $error("digest not shown");
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && rcnt == 7'd63) |=> state == S_FOLD) else $error("round count");
endmodule

// File: test/md5_message_digest_unit_tb.sv
// Self-checking testbench for the byte-serial MD5 digest unit.
`timescale 1ns / 1ps

module md5_message_digest_unit_tb;
  import md5_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;   // [7:0] data_byte
  logic         s_tuser;   // [0] byte_present
  logic         s_tlast;   // end_of_message
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // [63:0] digest_first_half, [127:64] digest_second_half

  md5_message_digest_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Digest model state.
  word_t       chain [4];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] bit_count;

  logic [127:0] digest_q [$];
  int errors = 0;
  int digests_seen = 0;
  int beats_sent = 0;
  int idle_pct = 18;
  bit hold_rx = 0;
  int quiet = 0;

  // Clock: period 20 ns.
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic word_t rotl(word_t v, int n);
    return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
  endfunction

  function automatic int shift_of(int r, int j);
    int s [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    return s[4*r + j];
  endfunction

  // Round constants are floor(abs(sin(i+1)) * 2^32).
  function automatic word_t step_k(int i);
    real s;
    s = $sin(i + 1);
    if (s < 0) s = -s;
    return word_t'(longint'($floor(s * 4294967296.0)));
  endfunction

  // One MD5 compression over the model's block buffer.
  task automatic md5_compress();
    word_t w [16];
    word_t a, b, c, d, f, t;
    int g;
    int r;
    int i;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (i = 0; i < 16; i++)
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    for (i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5*i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
      endcase
      t = a + f + w[g] + step_k(i);
      a = d; d = c; c = b;
      b = b + rotl(t, shift_of(r, i % 4));
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic reset_digest_model();
    chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
    fill = 0;
    bit_count = '0;
  endtask

  // Advance the model by one accepted beat; queue a digest on message end.
  task automatic predict_digest(logic [7:0] byte_in, logic present, logic last);
    int idx;
    int k;
    logic [63:0] first_half, second_half;
    if (present) begin
      blk[fill] = byte_in;
      fill = (fill + 1) % 64;
      bit_count += 64'd8;
      if (fill == 0) md5_compress();
    end
    if (last) begin
      idx = fill;
      blk[idx] = 8'h80;
      idx++;
      if (idx > 56) begin
        while (idx < 64) blk[idx++] = 8'h00;
        md5_compress();
        idx = 0;
      end
      while (idx < 56) blk[idx++] = 8'h00;
      for (k = 0; k < 8; k++) blk[56 + k] = bit_count[8*k +: 8];
      md5_compress();
      for (k = 0; k < 4; k++) begin
        first_half[63 - 8*k -: 8] = chain[0][8*k +: 8];
        first_half[31 - 8*k -: 8] = chain[1][8*k +: 8];
        second_half[63 - 8*k -: 8] = chain[2][8*k +: 8];
        second_half[31 - 8*k -: 8] = chain[3][8*k +: 8];
      end
      digest_q.push_back({second_half, first_half});
      reset_digest_model();
    end
  endtask

  // Send one beat, with random idle cycles before it.
  task automatic send_beat(logic [7:0] byte_in, logic present, logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= byte_in;
    s_tuser  <= present;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_digest(byte_in, present, last);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit with_gaps);
    int i;
    for (i = 0; i < len; i++) begin
      if (with_gaps && $urandom_range(9) == 0)
        send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, i == len - 1);
    end
    if (len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random stalls, or a full hold while hold_rx is set.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !hold_rx && ($urandom_range(99) >= idle_pct);
  end

  // Result checker and progress watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet > 20000) begin
        $display("%0t watchdog: no progress", $time);
        $display("status: fail");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        digests_seen++;
        if (digest_q.size() == 0) begin
          $display("%0t unexpected digest: actual %h", $time, m_tdata);
          errors++;
        end else begin
          if (m_tdata[63:0] !== digest_q[0][63:0]) begin
            $display("%0t digest_first_half: expected %h actual %h",
                     $time, digest_q[0][63:0], m_tdata[63:0]);
            errors++;
          end
          if (m_tdata[127:64] !== digest_q[0][127:64]) begin
            $display("%0t digest_second_half: expected %h actual %h",
                     $time, digest_q[0][127:64], m_tdata[127:64]);
            errors++;
          end
          void'(digest_q.pop_front());
        end
      end
    end
  end

  // Directed vectors: empty message, "abc", two short messages, and random data at lengths around the pad boundary.
  task automatic test_directed();
    int len [9] = '{0, 1, 55, 56, 63, 64, 65, 119, 120};
    int i;
    send_beat(8'hff, 1'b0, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h5a, 1'b1, 1'b0);
    send_beat(8'ha5, 1'b0, 1'b1);
    for (i = 0; i < 9; i++) send_message(len[i], 1'b0);
  endtask

  // Receiver blocked for a long stretch while messages keep coming.
  task automatic test_backpressure();
    int i;
    hold_rx = 1;
    fork
      begin
        for (i = 0; i < 4; i++) send_message($urandom_range(1, 8), 1'b0);
      end
      begin
        repeat (2000) @(negedge clk);
        hold_rx = 0;
      end
    join
  endtask

  // Random messages, mostly short, with absent-byte noise.
  task automatic test_random();
    int budget;
    budget = beats_sent + 1000;
    idle_pct = 0;
    while (beats_sent < budget) begin
      if (beats_sent > budget - 600) idle_pct = 18;
      case ($urandom_range(9))
        0: send_message(0, 1'b0);
        1: send_message($urandom_range(100, 200), 1'b1);
        default: send_message($urandom_range(1, 70), 1'b1);
      endcase
    end
  endtask

  initial begin
    int wait_cycles;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; s_tlast = 1'b0;
    m_tready = 1'b0;
    reset_digest_model();
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (digest_q.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (300) @(negedge clk);
    $display("Sent %0d beats; checked %0d digests, including boundary lengths and stalls.",
             beats_sent, digests_seen);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
